@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cp1251u8_pkg.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_pkg
// Types, constants and the code page mapping shared by the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cp1251u8_pkg;

  localparam int BYTE_W      = 8;
  localparam int CP_W        = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int CNT_W       = 2;

  // Number of UTF-8 bytes in one encoded character.
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  localparam logic [CP_W-1:0] CP_CYR_UPPER = 16'h0410;
  localparam logic [CP_W-1:0] CP_CYR_LOWER = 16'h0430;
  localparam logic [CP_W-1:0] CP_MAX_ONE   = 16'h007F;
  localparam logic [CP_W-1:0] CP_MAX_TWO   = 16'h07FF;

  localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
  localparam logic [BYTE_W-1:0] CONT_MARK  = 8'h80;

  typedef struct packed {
    logic [1:0]        len;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } char_t;

  // Code points of bytes 0x80 to 0xBF; slot 0x98 has no character and is
  // carried as the C1 control U+0098.
  function automatic logic [CP_W-1:0] upper_half_cp(input logic [5:0] idx);
    logic [CP_W-1:0] cp;
    case (idx)
      6'd0:  cp = 16'h0402;  6'd1:  cp = 16'h0403;
      6'd2:  cp = 16'h201A;  6'd3:  cp = 16'h0453;
      6'd4:  cp = 16'h201E;  6'd5:  cp = 16'h2026;
      6'd6:  cp = 16'h2020;  6'd7:  cp = 16'h2021;
      6'd8:  cp = 16'h20AC;  6'd9:  cp = 16'h2030;
      6'd10: cp = 16'h0409;  6'd11: cp = 16'h2039;
      6'd12: cp = 16'h040A;  6'd13: cp = 16'h040C;
      6'd14: cp = 16'h040B;  6'd15: cp = 16'h040F;
      6'd16: cp = 16'h0452;  6'd17: cp = 16'h2018;
      6'd18: cp = 16'h2019;  6'd19: cp = 16'h201C;
      6'd20: cp = 16'h201D;  6'd21: cp = 16'h2022;
      6'd22: cp = 16'h2013;  6'd23: cp = 16'h2014;
      6'd24: cp = 16'h0098;  6'd25: cp = 16'h2122;
      6'd26: cp = 16'h0459;  6'd27: cp = 16'h203A;
      6'd28: cp = 16'h045A;  6'd29: cp = 16'h045C;
      6'd30: cp = 16'h045B;  6'd31: cp = 16'h045F;
      6'd32: cp = 16'h00A0;  6'd33: cp = 16'h040E;
      6'd34: cp = 16'h045E;  6'd35: cp = 16'h0408;
      6'd36: cp = 16'h00A4;  6'd37: cp = 16'h0490;
      6'd38: cp = 16'h00A6;  6'd39: cp = 16'h00A7;
      6'd40: cp = 16'h0401;  6'd41: cp = 16'h00A9;
      6'd42: cp = 16'h0404;  6'd43: cp = 16'h00AB;
      6'd44: cp = 16'h00AC;  6'd45: cp = 16'h00AD;
      6'd46: cp = 16'h00AE;  6'd47: cp = 16'h0407;
      6'd48: cp = 16'h00B0;  6'd49: cp = 16'h00B1;
      6'd50: cp = 16'h0406;  6'd51: cp = 16'h0456;
      6'd52: cp = 16'h0491;  6'd53: cp = 16'h00B5;
      6'd54: cp = 16'h00B6;  6'd55: cp = 16'h00B7;
      6'd56: cp = 16'h0451;  6'd57: cp = 16'h2116;
      6'd58: cp = 16'h0454;  6'd59: cp = 16'h00BB;
      6'd60: cp = 16'h0458;  6'd61: cp = 16'h0405;
      6'd62: cp = 16'h0455;  6'd63: cp = 16'h0457;
      default: cp = 16'h0000;
    endcase
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] unicode_of(input logic [BYTE_W-1:0] b);
    logic [CP_W-1:0] cp;
    if (!b[7]) begin
      cp = {8'h00, b};
    end else if (!b[6]) begin
      cp = upper_half_cp(b[5:0]);
    end else if (!b[5]) begin
      cp = CP_CYR_UPPER + {11'd0, b[4:0]};
    end else begin
      cp = CP_CYR_LOWER + {11'd0, b[4:0]};
    end
    return cp;
  endfunction

  function automatic char_t encode(input logic [CP_W-1:0] cp);
    char_t c;
    c = '0;
    if (cp <= CP_MAX_ONE) begin
      c.len = LEN_ONE;
      c.b0  = cp[7:0];
    end else if (cp <= CP_MAX_TWO) begin
      c.len = LEN_TWO;
      c.b0  = LEAD_TWO  | {3'd0, cp[10:6]};
      c.b1  = CONT_MARK | {2'd0, cp[5:0]};
    end else begin
      c.len = LEN_THREE;
      c.b0  = LEAD_THREE | {4'd0, cp[15:12]};
      c.b1  = CONT_MARK  | {2'd0, cp[11:6]};
      c.b2  = CONT_MARK  | {2'd0, cp[5:0]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cp1251u8_in_if.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_in_if
// Input channel: one Windows-1251 byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cp1251u8_in_if;
  logic                              valid;
  logic                              ready;
  logic [cp1251u8_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cp1251u8_out_if.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_out_if
// Output channel: one UTF-8 byte per item, the final byte of a character marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface cp1251u8_out_if;
  logic                              valid;
  logic                              ready;
  logic [cp1251u8_pkg::BYTE_W-1:0]   out_byte;
  logic                              last_of_char;

  modport source (output valid, output out_byte, output last_of_char, input ready);
  modport sink   (input valid, input out_byte, input last_of_char, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cp1251u8_front.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_front
// Maps each accepted byte to its code point and its complete UTF-8 encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module cp1251u8_front (
  cp1251u8_in_if.sink           cp1251,
  output logic                  push_valid,
  output cp1251u8_pkg::char_t   push_data,
  input  logic                  push_ready
);
  import cp1251u8_pkg::*;

  // The byte is taken as soon as the queue has a free slot.
  assign cp1251.ready = push_ready;
  assign push_valid   = cp1251.valid;
  assign push_data    = encode(unicode_of(cp1251.in_byte));

endmodule

`default_nettype wire

@@ hw/rtl/cp1251u8_queue.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_queue
// Two-entry queue of encoded characters between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cp1251u8_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  input  cp1251u8_pkg::char_t   push_data,
  output logic                  push_ready,
  output logic                  head_valid,
  output cp1251u8_pkg::char_t   head_data,
  input  logic                  pop
);
  import cp1251u8_pkg::*;

  char_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              take;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign take       = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cp1251u8_back.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_back
// Serialises each encoded character into single bytes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cp1251u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  cp1251u8_pkg::char_t   head_data,
  output logic                  pop,
  cp1251u8_out_if.source        utf8
);
  import cp1251u8_pkg::*;

  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic [BYTE_W-1:0] rem1;
  logic [BYTE_W-1:0] rem2;
  logic [1:0]        rem_cnt;
  logic              load;

  assign load = !out_valid || utf8.ready;
  assign pop  = load && (rem_cnt == '0) && head_valid;

  assign utf8.valid        = out_valid;
  assign utf8.out_byte     = out_byte;
  assign utf8.last_of_char = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem_cnt   <= '0;
    end else if (load) begin
      if (rem_cnt != '0) begin
        out_valid <= 1'b1;
        out_byte  <= rem1;
        out_last  <= (rem_cnt == 2'd1);
        rem1      <= rem2;
        rem_cnt   <= rem_cnt - 1'b1;
      end else if (head_valid) begin
        out_valid <= 1'b1;
        out_byte  <= head_data.b0;
        out_last  <= (head_data.len == LEN_ONE);
        rem1      <= head_data.b1;
        rem2      <= head_data.b2;
        rem_cnt   <= head_data.len - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cp1251_to_utf8_transcoder_top.sv @@
// ----------------------------------------------------------------------------
// cp1251_to_utf8_transcoder_top
// Windows-1251 to UTF-8 transcoder: one code page byte in, one to three bytes out.
// ----------------------------------------------------------------------------
// Each input item is one Windows-1251 byte and yields its UTF-8 encoding as one
// to three output items of one byte each, the final byte of every character
// carrying last_of_char. ASCII takes one byte, Cyrillic letters and most
// symbols take two, and the typographic punctuation, the euro sign, the
// numero and trade mark signs take three; the undefined slot 0x98 comes out as
// C2 98. The output serialiser sends one byte per cycle while the output is
// ready, so multi-byte characters take longer to send and set the sustained
// input rate. Intake itself is one item per cycle while the two-entry
// character queue has room, so the input side keeps accepting while a
// finished byte waits in the output register. An accepted input item is
// written into the queue, and its first output byte is then loaded into the
// output register. The block holds no state beyond its queue and serialiser;
// reset only empties them.
// ----------------------------------------------------------------------------
`default_nettype none

module cp1251_to_utf8_transcoder_top (
  input  logic            clk,
  input  logic            rst,
  cp1251u8_in_if.sink     cp1251,
  cp1251u8_out_if.source  utf8
);
  import cp1251u8_pkg::*;

  // Front to queue: a fully encoded character.
  logic  push_valid;
  logic  push_ready;
  char_t push_data;

  // Queue to back: the oldest pending character.
  logic  head_valid;
  char_t head_data;
  logic  pop;

  // The front decodes the byte and builds all of its UTF-8 bytes at once.
  cp1251u8_front u_front (
    .cp1251     (cp1251),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // The queue decouples intake from the byte-at-a-time output.
  cp1251u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // The back part hands out one byte per cycle while the output is ready, and takes
  // each character from the queue in the cycle its first byte is loaded.
  cp1251u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .utf8       (utf8)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cp1251u8_checker.sv @@
// ----------------------------------------------------------------------------
// cp1251u8_checker
// Port-level checks on the output byte stream of the transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cp1251u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_char
);

  // A stalled output item stays offered.
  `CHK_NEXT(a_valid_hold, clk, rst, out_valid && !out_ready, out_valid, "output valid dropped while stalled")

  // A stalled output item keeps its payload.
  `CHK_NEXT(a_data_hold, clk, rst, out_valid && !out_ready, $stable(out_byte) && $stable(last_of_char), "output payload changed while stalled")

  // A single-byte character always closes itself.
  `CHK_SAME(a_ascii_last, clk, rst, out_valid && !out_byte[7], last_of_char, "ASCII byte not marked last")

  // A lead byte never ends a character.
  `CHK_SAME(a_lead_not_last, clk, rst, out_valid && out_byte[7] && out_byte[6], !last_of_char, "lead byte marked last")

endmodule

bind cp1251_to_utf8_transcoder_top cp1251u8_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (utf8.valid),
  .out_ready    (utf8.ready),
  .out_byte     (utf8.out_byte),
  .last_of_char (utf8.last_of_char)
);

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Windows-1251 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
// Code page bytes are sent through the input channel, and every UTF-8 byte
// that comes back is compared with a scoreboard. The scoreboard is filled by
// an encoder written inside the bench, or by hand-typed bytes for the
// directed rows whose encoding is obvious. The bench covers the range ends,
// all four mapping regions, the unassigned slot 0x98 and the three-byte
// symbols. A random run follows. Both sides pause at random, with bursts
// that run at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cp1251u8_pkg::*;

  localparam int RANDOM_ITEMS = 206;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_IDLE     = 6;

  // One UTF-8 byte as the output channel carries it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } utf8_byte_t;

  // One row of the directed table. A byte count of zero means that the row
  // has no hand-typed encoding, so the encoder in the bench supplies it.
  typedef struct packed {
    logic [BYTE_W-1:0] cp1251;
    logic [1:0]        n_bytes;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } directed_row_t;

  localparam int N_DIRECTED = 24;

  // The rows cover both ends of the byte range, and both ends of every
  // mapping region. They also cover the unassigned slot 0x98 (C2 98), the
  // euro, trade mark and numero signs that take three bytes, and a spread
  // of ordinary bytes.
  localparam directed_row_t DIRECTED_TABLE [0:N_DIRECTED-1] = '{
    '{8'h00, 2'd1, 8'h00, 8'h00, 8'h00},
    '{8'h7F, 2'd1, 8'h7F, 8'h00, 8'h00},
    '{8'h80, 2'd2, 8'hD0, 8'h82, 8'h00},
    '{8'h88, 2'd3, 8'hE2, 8'h82, 8'hAC},
    '{8'h98, 2'd2, 8'hC2, 8'h98, 8'h00},
    '{8'h99, 2'd3, 8'hE2, 8'h84, 8'hA2},
    '{8'hA0, 2'd2, 8'hC2, 8'hA0, 8'h00},
    '{8'hBF, 2'd2, 8'hD1, 8'h97, 8'h00},
    '{8'hC0, 2'd2, 8'hD0, 8'h90, 8'h00},
    '{8'hDF, 2'd2, 8'hD0, 8'hAF, 8'h00},
    '{8'hE0, 2'd2, 8'hD0, 8'hB0, 8'h00},
    '{8'hFF, 2'd2, 8'hD1, 8'h8F, 8'h00},
    '{8'h55, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hAA, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h85, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h96, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hB9, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h8B, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hAD, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hC5, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hEF, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h01, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'h3F, 2'd0, 8'h00, 8'h00, 8'h00},
    '{8'hF5, 2'd0, 8'h00, 8'h00, 8'h00}
  };

  // Code points of the upper half, bytes 0x80 to 0xBF.
  localparam logic [15:0] UPPER_HALF_CP [0:63] = '{
    16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h0098, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
    16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
    16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
    16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
    16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

  logic clk = 1'b0;
  logic rst;

  cp1251u8_in_if  cp1251_ch ();
  cp1251u8_out_if utf8_ch ();

  cp1251_to_utf8_transcoder_top uut (
    .clk    (clk),
    .rst    (rst),
    .cp1251 (cp1251_ch),
    .utf8   (utf8_ch)
  );

  // UTF-8 bytes still owed by the block, oldest first.
  utf8_byte_t utf8_expected [$];
  int         error_count   = 0;
  int         cycle_count   = 0;
  bit         stimulus_done = 1'b0;

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Appends one owed byte to the end of the scoreboard.
  function automatic void add_expected(input logic [BYTE_W-1:0] d, input logic l);
    utf8_byte_t e;
    e.data = d;
    e.last = l;
    utf8_expected.insert(utf8_expected.size(), e);
  endfunction

  // Works out the UTF-8 bytes for one code page byte and queues them.
  task automatic queue_utf8_of(input logic [BYTE_W-1:0] b);
    logic [15:0]       cp;
    logic [BYTE_W-1:0] enc [3];
    int                n;
    if (b < 8'h80) begin
      cp = {8'h00, b};
    end else if (b < 8'hC0) begin
      cp = UPPER_HALF_CP[b[5:0]];
    end else if (b < 8'hE0) begin
      cp = 16'h0410 + {8'h00, b - 8'hC0};
    end else begin
      cp = 16'h0430 + {8'h00, b - 8'hE0};
    end
    if (cp <= 16'h007F) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp <= 16'h07FF) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n = 2;
    end else begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n = 3;
    end
    for (int i = 0; i < n; i++) begin
      add_expected(enc[i], (i == n - 1));
    end
  endtask

  // Draws a pause, but none while a full-rate burst is running.
  function automatic int draw_idle(input bit burst);
    return burst ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // Offers one byte and holds it until the block takes it. Valid is only
  // lowered when a pause is drawn, so a back-to-back item never sees valid
  // dropped and raised within one time step.
  task automatic send_cp1251(input logic [BYTE_W-1:0] b, input int idle);
    if (idle > 0) begin
      cp1251_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    cp1251_ch.valid   <= 1'b1;
    cp1251_ch.in_byte <= b;
    do @(posedge clk); while (!cp1251_ch.ready);
  endtask

  // Start-up values, then reset is held and released.
  initial begin
    rst                <= 1'b1;
    cp1251_ch.valid    <= 1'b0;
    cp1251_ch.in_byte  <= '0;
    utf8_ch.ready      <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Input side: the directed table first, then random bytes.
  initial begin
    bit                burst;
    logic [BYTE_W-1:0] b;
    burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);

    foreach (DIRECTED_TABLE[i]) begin
      send_cp1251(DIRECTED_TABLE[i].cp1251, draw_idle(burst));
      // Rows with a hand-typed encoding are checked against it, so that a
      // slip in the bench's own encoder cannot hide a matching slip in the
      // block.
      if (DIRECTED_TABLE[i].n_bytes == 2'd0) begin
        queue_utf8_of(DIRECTED_TABLE[i].cp1251);
      end else begin
        add_expected(DIRECTED_TABLE[i].b0, (DIRECTED_TABLE[i].n_bytes == 2'd1));
        if (DIRECTED_TABLE[i].n_bytes >= 2'd2) begin
          add_expected(DIRECTED_TABLE[i].b1, (DIRECTED_TABLE[i].n_bytes == 2'd2));
        end
        if (DIRECTED_TABLE[i].n_bytes == 2'd3) begin
          add_expected(DIRECTED_TABLE[i].b2, 1'b1);
        end
      end
    end

    // The random part leans on the upper half and the Cyrillic letters,
    // where the two- and three-byte encodings live. A quarter of the bytes
    // are drawn over the whole range. Bursts at full rate start and end at
    // random.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        burst = !burst;
      end
      case ($urandom_range(0, 3))
        0: b = BYTE_W'($urandom_range(0, 255));
        1: b = BYTE_W'($urandom_range(8'h00, 8'h7F));
        2: b = BYTE_W'($urandom_range(8'h80, 8'hBF));
        default: b = BYTE_W'($urandom_range(8'hC0, 8'hFF));
      endcase
      send_cp1251(b, draw_idle(burst));
      queue_utf8_of(b);
    end
    cp1251_ch.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Output side: stalls at random and checks every byte it takes against
  // the oldest entry of the scoreboard. Outputs are sampled at the clock
  // edge, so each value is the one that was present during the handshake.
  initial begin
    bit         burst;
    int         stall;
    utf8_byte_t want;
    burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        burst = !burst;
      end
      stall = draw_idle(burst);
      if (stall > 0) begin
        utf8_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      utf8_ch.ready <= 1'b1;
      do @(posedge clk); while (!utf8_ch.valid);
      if (utf8_expected.size() == 0) begin
        $error("out_byte: no byte expected, got %h (last_of_char %b)",
               utf8_ch.out_byte, utf8_ch.last_of_char);
        error_count++;
      end else begin
        want = utf8_expected.pop_front();
        if (utf8_ch.out_byte !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, utf8_ch.out_byte);
          error_count++;
        end
        if (utf8_ch.last_of_char !== want.last) begin
          $error("last_of_char: expected %b, got %b", want.last,
                 utf8_ch.last_of_char);
          error_count++;
        end
      end
    end
  end

  // End of run: once every byte has come back, a drain wait catches any stray
  // output before the verdict.
  initial begin
    wait (stimulus_done);
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cp1251u8_pkg.sv
hw/rtl/cp1251u8_in_if.sv
hw/rtl/cp1251u8_out_if.sv
hw/rtl/cp1251u8_front.sv
hw/rtl/cp1251u8_queue.sv
hw/rtl/cp1251u8_back.sv
hw/rtl/cp1251_to_utf8_transcoder_top.sv
hw/rtl/cp1251u8_checker.sv
verif/tb.sv
